>>> hdl/lbe_pkg.sv
// shared constants and register codes for the label boundary extractor
package lbe_pkg;

    localparam int DEF_RADIUS     = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_LABEL_BITS = 16;

    localparam int LABEL_PORT_BITS = 16;
    localparam int DIM_BITS        = 11;
    localparam int CFG_DATA_BITS   = 25;
    localparam int CFG_INDEX_BITS  = 2;

    localparam int FRAME_DIM_RESET = 1024;
    localparam logic [CFG_DATA_BITS-1:0] MASK_RESET = 25'd469440;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_NEIGHBOR_MASK = 2'd2
    } cfg_reg_t;

endpackage

>>> hdl/lbe_line_store.sv
// rotating line stores, one memory per window row, with registered column read
module lbe_line_store #(
    parameter int WIN       = 5,
    parameter int MAX_WIDTH = 1024,
    parameter int LW        = 16,
    localparam int SW = $clog2(WIN),
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [SW-1:0]            slot,
    input  logic [AW-1:0]            addr,
    input  logic [LW-1:0]            wdata,
    output logic [WIN-1:0][LW-1:0]   col_out
);

    logic [LW-1:0] rd_q [WIN];
    logic [LW-1:0] lab_reg;
    logic [SW-1:0] slot_reg;

    for (genvar s = 0; s < WIN; s++) begin : g_slot
        logic [LW-1:0] line_mem [MAX_WIDTH];
        logic [LW-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && slot == SW'(s)) begin
                line_mem[addr] <= wdata;
            end
            if (rd_en) begin
                rd_reg <= line_mem[addr];
            end
        end

        assign rd_q[s] = rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lab_reg  <= wdata;
            slot_reg <= slot;
        end
    end

    // entry j is the row j lines above the newest one
    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            if (j == 0) begin
                col_out[j] = lab_reg;
            end else if (int'(slot_reg) >= j) begin
                col_out[j] = rd_q[SW'(int'(slot_reg) - j)];
            end else begin
                col_out[j] = rd_q[SW'(int'(slot_reg) + WIN - j)];
            end
        end
    end

endmodule

>>> hdl/lbe_window_cell.sv
// one window column: holds a column of labels, shifts it on, compares it to the center
module lbe_window_cell #(
    parameter int WIN = 5,
    parameter int LW  = 16
) (
    input  logic                     aclk,
    input  logic                     shift_en,
    input  logic [WIN-1:0][LW-1:0]   col_in,
    input  logic [LW-1:0]            center,
    input  logic [WIN-1:0]           mask_col,
    input  logic [WIN-1:0]           row_ok,
    input  logic                     col_ok,
    output logic [WIN-1:0][LW-1:0]   col_out,
    output logic                     hit
);

    logic [WIN-1:0][LW-1:0] col_reg;
    logic [WIN-1:0]         diff;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            diff[j] = (col_reg[j] != center);
        end
    end

    // the center compares equal to itself, so its mask bit never matters
    assign hit     = col_ok && (|(mask_col & row_ok & diff));
    assign col_out = col_reg;

endmodule

>>> hdl/label_boundary_extractor.sv
// top level: raster position control, line stores, window cell chain, output register
//
// channel  dir  handshake              payload
// s_       in   s_valid / s_ready      s_command, s_label
// m_       out  m_valid / m_ready      m_boundary_label, m_frame_last
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a taken beat passes the line store read, the window shift and the compare into the output
// register before its result is valid; one beat per clock while s_ready stays high
// s_ready drops while the output register holds an untaken beat, during a register write,
// and while the window is shifted on to line up once a frame smaller than the lag is fully in
// synchronous active-low reset zeroes positions and valid bits; line stores are not cleared
// cfg_ready is always high; width or height writes restart the frame
module label_boundary_extractor
    import lbe_pkg::*;
#(
    parameter int RADIUS     = DEF_RADIUS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [LABEL_PORT_BITS-1:0]  s_label,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [LABEL_PORT_BITS-1:0]  m_boundary_label,
    output logic                        m_frame_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int WIN = 2 * RADIUS + 1;
    localparam int NB  = WIN * WIN;
    localparam int MW  = (NB > CFG_DATA_BITS) ? NB : CFG_DATA_BITS;
    localparam int LW  = (LABEL_BITS < LABEL_PORT_BITS) ? LABEL_BITS : LABEL_PORT_BITS;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = $clog2(WIN);
    localparam int LDW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int W_RESET = (FRAME_DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_DIM_RESET;
    localparam int H_RESET = (FRAME_DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_DIM_RESET;
    localparam logic [MW-1:0] MASK_INIT = MW'(MASK_RESET);

    // configuration
    logic [WW-1:0]  w_reg, w_next, w_clamp;
    logic [RW-1:0]  h_reg, h_next, h_clamp;
    logic [NB-1:0]  mask_reg, mask_next;
    logic [MW-1:0]  cfg_ext;
    logic [DIM_BITS-1:0] dim;

    // positions
    logic [AW-1:0]  in_col_reg, in_col_next, col_base;
    logic [RW-1:0]  in_row_reg, in_row_next, row_base;
    logic [SW-1:0]  slot_reg, slot_next, slot_base;
    logic [AW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [LDW-1:0] lead_reg, lead_next, lead_base, lag;

    // stage control
    logic           s1_shift_reg, s1_emit_reg, s1_last_reg;
    logic [WIN-1:0] s1_row_ok_reg, s1_col_ok_reg;
    logic           s2_emit_reg, s2_last_reg;
    logic [WIN-1:0] s2_row_ok_reg, s2_col_ok_reg;
    logic           m_valid_reg, m_valid_next;
    logic [LABEL_PORT_BITS-1:0] m_label_reg;
    logic           m_last_reg;

    logic           en, accept, is_pix, frame_done, restart, take, emit;
    logic           pad, pad_step;
    logic           col_wrap, out_last;
    logic [WIN-1:0] row_ok, col_ok;

    logic [WIN-1:0][LW-1:0] ls_col;
    logic [WIN-1:0][LW-1:0] win_col [WIN];
    logic [WIN-1:0]         cell_mask [WIN];
    logic [WIN-1:0]         hit;
    logic [LW-1:0]          center;
    logic [LABEL_PORT_BITS-1:0] result;

    assign en        = !m_valid_reg || m_ready;
    assign frame_done = (in_row_reg >= h_reg);
    // a frame smaller than the lag is shifted on internally until the window lines up
    assign pad       = frame_done && (lead_reg != lag);
    assign pad_step  = en && pad && !cfg_valid;
    assign s_ready   = en && !pad && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign is_pix    = accept && (s_command == CMD_PIXEL);
    assign restart   = is_pix && frame_done;
    // a flush moves the window only once the frame is fully in
    assign take      = is_pix || (accept && frame_done) || pad_step;
    assign lag       = LDW'(RADIUS) * LDW'(w_reg) + LDW'(RADIUS);

    assign col_base  = restart ? '0 : in_col_reg;
    assign row_base  = restart ? '0 : in_row_reg;
    assign slot_base = restart ? '0 : slot_reg;
    assign lead_base = restart ? '0 : lead_reg;

    assign emit      = (is_pix && (lead_base == lag)) || (accept && !is_pix && frame_done);
    assign col_wrap  = (WW'(col_base) + WW'(1)) >= w_reg;
    assign out_last  = (out_row_reg == (h_reg - RW'(1))) && (out_col_reg == AW'(w_reg - WW'(1)));

    // in-frame flags for the rows and columns around the next result
    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            row_ok[j] = (int'(out_row_reg) + RADIUS - j >= 0) &&
                        (int'(out_row_reg) + RADIUS - j < int'(h_reg));
            col_ok[j] = (int'(out_col_reg) + RADIUS - j >= 0) &&
                        (int'(out_col_reg) + RADIUS - j < int'(w_reg));
        end
    end

    // register value clamping
    always_comb begin
        dim     = cfg_data[DIM_BITS-1:0];
        cfg_ext = MW'(cfg_data);
        if (dim == '0) begin
            w_clamp = WW'(1);
        end else if (int'(dim) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(dim);
        end
        if (dim == '0) begin
            h_clamp = RW'(1);
        end else if (int'(dim) > MAX_HEIGHT) begin
            h_clamp = RW'(MAX_HEIGHT);
        end else begin
            h_clamp = RW'(dim);
        end
    end

    always_comb begin
        w_next       = w_reg;
        h_next       = h_reg;
        mask_next    = mask_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        slot_next    = slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    w_next       = w_clamp;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    slot_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    lead_next    = '0;
                end
                REG_FRAME_HEIGHT: begin
                    h_next       = h_clamp;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    slot_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    lead_next    = '0;
                end
                REG_NEIGHBOR_MASK: begin
                    mask_next = cfg_ext[NB-1:0];
                end
                default: begin
                end
            endcase
        end else if (take) begin
            in_row_next  = row_base;
            slot_next    = slot_base;
            out_col_next = restart ? '0 : out_col_reg;
            out_row_next = restart ? '0 : out_row_reg;
            if (col_wrap) begin
                in_col_next = '0;
                slot_next   = (slot_base == SW'(WIN - 1)) ? '0 : slot_base + SW'(1);
                if (is_pix) begin
                    in_row_next = row_base + RW'(1);
                end
            end else begin
                in_col_next = col_base + AW'(1);
            end
            if (is_pix) begin
                lead_next = emit ? lead_base : lead_base + LDW'(1);
            end else if (pad_step) begin
                lead_next = lead_reg + LDW'(1);
            end
            if (emit) begin
                if (out_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    slot_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    lead_next    = '0;
                end else if ((WW'(out_col_reg) + WW'(1)) >= w_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (en) begin
            m_valid_next = s2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= WW'(W_RESET);
            h_reg        <= RW'(H_RESET);
            mask_reg     <= MASK_INIT[NB-1:0];
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            slot_reg     <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            lead_reg     <= '0;
            s1_shift_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_emit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            mask_reg     <= mask_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            slot_reg     <= slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            lead_reg     <= lead_next;
            m_valid_reg  <= m_valid_next;
            if (en) begin
                s1_shift_reg <= take;
                s1_emit_reg  <= emit;
                s2_emit_reg  <= s1_emit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_last_reg   <= out_last;
            s1_row_ok_reg <= row_ok;
            s1_col_ok_reg <= col_ok;
            s2_last_reg   <= s1_last_reg;
            s2_row_ok_reg <= s1_row_ok_reg;
            s2_col_ok_reg <= s1_col_ok_reg;
            m_label_reg   <= result;
            m_last_reg    <= s2_last_reg;
        end
    end

    lbe_line_store #(
        .WIN       (WIN),
        .MAX_WIDTH (MAX_WIDTH),
        .LW        (LW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (take),
        .wr_en   (take && is_pix),
        .slot    (slot_base),
        .addr    (col_base),
        .wdata   (LW'(s_label)),
        .col_out (ls_col)
    );

    // cell k holds the column RADIUS-k to the right of the center
    for (genvar k = 0; k < WIN; k++) begin : g_cell
        for (genvar j = 0; j < WIN; j++) begin : g_mask
            assign cell_mask[k][j] = mask_reg[(WIN - 1 - j) * WIN + (WIN - 1 - k)];
        end

        lbe_window_cell #(
            .WIN (WIN),
            .LW  (LW)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (en && s1_shift_reg),
            .col_in   ((k == 0) ? ls_col : win_col[(k == 0) ? 0 : k - 1]),
            .center   (center),
            .mask_col (cell_mask[k]),
            .row_ok   (s2_row_ok_reg),
            .col_ok   (s2_col_ok_reg[k]),
            .col_out  (win_col[k]),
            .hit      (hit[k])
        );
    end

    assign center = win_col[RADIUS][RADIUS];
    assign result = ((center != '0) && (|hit)) ? LABEL_PORT_BITS'(center) : '0;

    assign m_valid          = m_valid_reg;
    assign m_boundary_label = m_label_reg;
    assign m_frame_last     = m_last_reg;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the label boundary extractor with a built-in boundary predictor
module tb;
    import lbe_pkg::*;

    localparam int RADIUS         = DEF_RADIUS;
    localparam int WIN            = 2 * RADIUS + 1;
    localparam int MAXW           = DEF_MAX_WIDTH;
    localparam int MAXH           = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED       = 2'd3;
    localparam logic [CFG_DATA_BITS-1:0]  MASK_ALL         = '1;
    localparam logic [CFG_DATA_BITS-1:0]  MASK_NONE        = '0;
    localparam logic [CFG_DATA_BITS-1:0]  MASK_CENTER_ONLY = 25'd1 << (RADIUS * WIN + RADIUS);

    typedef struct packed {
        logic                       cmd;
        logic [LABEL_PORT_BITS-1:0] label;
    } beat_t;

    typedef struct packed {
        logic [LABEL_PORT_BITS-1:0] label;
        logic                       last;
    } boundary_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_command = CMD_PIXEL;
    logic [LABEL_PORT_BITS-1:0] s_label = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [LABEL_PORT_BITS-1:0] m_boundary_label;
    logic                       m_frame_last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

    label_boundary_extractor DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_label          (s_label),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_boundary_label (m_boundary_label),
        .m_frame_last     (m_frame_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 aclk = ~aclk;

    // predictor state
    logic [LABEL_PORT_BITS-1:0] label_rows [WIN * MAXW];
    logic [DIM_BITS-1:0]        frame_w_reg = DIM_BITS'(FRAME_DIM_RESET);
    logic [DIM_BITS-1:0]        frame_h_reg = DIM_BITS'(FRAME_DIM_RESET);
    logic [CFG_DATA_BITS-1:0]   mask_reg = MASK_RESET;
    int px_row = 0;
    int px_col = 0;
    int res_row = 0;
    int res_col = 0;

    beat_t     beat_q [$];
    boundary_t boundary_q [$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int beats_queued = 0;
    int beats_accepted = 0;
    int pixel_beats = 0;
    int flush_beats = 0;
    int results_seen = 0;
    int boundary_hits = 0;
    int frames_done = 0;
    int reg_writes = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    // stimulus label pattern
    logic [LABEL_PORT_BITS-1:0] palette [3];
    int shift_x = 0;
    int shift_y = 0;
    int noise_pct = 0;

    function automatic int active_width();
        if (frame_w_reg == 0) return 1;
        if (frame_w_reg > MAXW) return MAXW;
        return frame_w_reg;
    endfunction

    function automatic int active_height();
        if (frame_h_reg == 0) return 1;
        if (frame_h_reg > MAXH) return MAXH;
        return frame_h_reg;
    endfunction

    function automatic void restart_frame();
        px_row = 0;
        px_col = 0;
        res_row = 0;
        res_col = 0;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_FRAME_WIDTH: begin
                frame_w_reg = value[DIM_BITS-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT: begin
                frame_h_reg = value[DIM_BITS-1:0];
                restart_frame();
            end
            REG_NEIGHBOR_MASK: begin
                mask_reg = value;
            end
            default: begin
            end
        endcase
    endfunction

    // boundary decision for the pixel at the result position, then advance it
    function automatic void emit_boundary();
        int w, h, y, x, dy, dx;
        logic [LABEL_PORT_BITS-1:0] center, res;
        boundary_t r;
        w = active_width();
        h = active_height();
        center = label_rows[(res_row % WIN) * MAXW + res_col];
        res = '0;
        if (center != 0) begin
            for (dy = -RADIUS; dy <= RADIUS; dy++) begin
                for (dx = -RADIUS; dx <= RADIUS; dx++) begin
                    y = res_row + dy;
                    x = res_col + dx;
                    if (!(dy == 0 && dx == 0) && y >= 0 && x >= 0 && y < h && x < w) begin
                        if (mask_reg[(dy + RADIUS) * WIN + dx + RADIUS] &&
                            label_rows[(y % WIN) * MAXW + x] != center)
                            res = center;
                    end
                end
            end
        end
        r.label = res;
        r.last = (res_row == h - 1) && (res_col == w - 1);
        boundary_q.push_back(r);
        if (r.last) begin
            restart_frame();
        end else begin
            res_col++;
            if (res_col >= w) begin
                res_col = 0;
                res_row++;
            end
        end
    endfunction

    function automatic void predict_boundary(input logic cmd,
                                             input logic [LABEL_PORT_BITS-1:0] label);
        int w, h, lag, rcv, sent;
        w = active_width();
        h = active_height();
        lag = RADIUS * w + RADIUS;
        if (cmd == CMD_PIXEL) begin
            // a pixel after a finished frame drops whatever is still pending
            if (px_row >= h) restart_frame();
            label_rows[(px_row % WIN) * MAXW + px_col] = label;
            px_col++;
            if (px_col >= w) begin
                px_col = 0;
                px_row++;
            end
            rcv = px_row * w + px_col;
            sent = res_row * w + res_col;
            if (rcv - sent > lag) emit_boundary();
        end else begin
            sent = res_row * w + res_col;
            if (px_row >= h && sent < h * w) emit_boundary();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // driver
    always @(posedge aclk) begin : drive_beats
        beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_boundary(s_command, s_label);
                beats_accepted++;
                if (s_command == CMD_PIXEL) pixel_beats++;
                else flush_beats++;
            end
            if (!s_valid || s_ready) begin
                if (beat_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.cmd;
                    s_label <= nxt.label;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : watch_results
        boundary_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_frame_last) frames_done++;
                if (m_boundary_label != 0) boundary_hits++;
                if (boundary_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = boundary_q.pop_front();
                    if (m_boundary_label !== want.label)
                        report_mismatch($sformatf("result %0d label %h, expected %h",
                                                  results_seen, m_boundary_label, want.label));
                    if (m_frame_last !== want.last)
                        report_mismatch($sformatf("result %0d frame_last %b, expected %b",
                                                  results_seen, m_frame_last, want.last));
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, boundary_q.size());
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_beat(input logic cmd, input logic [LABEL_PORT_BITS-1:0] label);
        beat_t b;
        b.cmd = cmd;
        b.label = label;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic push_flushes(input int count);
        repeat (count) push_beat(CMD_FLUSH, '0);
    endtask

    function automatic logic [LABEL_PORT_BITS-1:0] region_label(input int x, input int y);
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(99) < noise_pct) return r[LABEL_PORT_BITS-1:0];
        return palette[((x >> shift_x) + (y >> shift_y)) % 3];
    endfunction

    task automatic new_palette();
        logic [31:0] r;
        for (int i = 0; i < 3; i++) begin
            r = $urandom;
            case ($urandom_range(3))
                0: palette[i] = '0;
                1: palette[i] = r[LABEL_PORT_BITS-1:0];
                2: palette[i] = '1;
                default: palette[i] = LABEL_PORT_BITS'($urandom_range(1, 7));
            endcase
        end
        shift_x = $urandom_range(2);
        shift_y = $urandom_range(2);
        noise_pct = $urandom_range(15);
    endtask

    // raster pixels first..first+count-1 of the current geometry
    task automatic push_pixels(input int first, input int count);
        int w;
        w = active_width();
        for (int i = first; i < first + count; i++)
            push_beat(CMD_PIXEL, region_label(i % w, i / w));
    endtask

    // called just after aclk rises; valid stays up for a following write
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, value);
        reg_writes++;
    endtask

    task automatic set_geometry(input int w, input int h, input logic [CFG_DATA_BITS-1:0] mask);
        logic [31:0] r;
        r = $urandom;
        write_register(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
        write_register(REG_NEIGHBOR_MASK, mask);
        if ($urandom_range(5) == 0) write_register(REG_UNUSED, r[CFG_DATA_BITS-1:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_mask();
        logic [31:0] a, b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(9))
            0: return MASK_ALL;
            1: return MASK_NONE;
            2: return MASK_RESET;
            3: return MASK_CENTER_ONLY;
            4: return a[CFG_DATA_BITS-1:0] & b[CFG_DATA_BITS-1:0];
            default: return a[CFG_DATA_BITS-1:0];
        endcase
    endfunction

    // wait until every queued beat is in and every result is out, then let the pipe empty
    task automatic drain();
        while (beats_accepted != beats_queued || boundary_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_frames(input int target);
        int done_beats, w, h, n, lag, pend, k, kind;
        done_beats = 0;
        while (done_beats < target) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 7);
            // width or height 0 behaves as 1
            set_geometry((w == 1 && $urandom_range(1) == 0) ? 0 : w,
                         (h == 1 && $urandom_range(1) == 0) ? 0 : h, pick_mask());
            w = active_width();
            h = active_height();
            n = w * h;
            lag = RADIUS * w + RADIUS;
            pend = (n < lag) ? n : lag;
            new_palette();
            kind = $urandom_range(99);
            if (kind < 65) begin
                if ($urandom_range(3) == 0) begin
                    // flush in the middle of a frame is ignored
                    push_pixels(0, n / 2);
                    push_flushes(1);
                    push_pixels(n / 2, n - n / 2);
                end else begin
                    push_pixels(0, n);
                end
                push_flushes(pend);
                if ($urandom_range(3) == 0) push_flushes(1);
                done_beats += n + pend;
            end else if (kind < 78) begin
                // partial frame, dropped by the next geometry write
                k = $urandom_range(0, n - 1);
                push_pixels(0, k);
                push_flushes(1);
                done_beats += k;
            end else if (kind < 90) begin
                // new frame starts while results of the old one are still pending
                k = $urandom_range(0, pend - 1);
                push_pixels(0, n);
                push_flushes(k);
                new_palette();
                push_pixels(0, n);
                push_flushes(pend);
                done_beats += 2 * n + k + pend;
            end else begin
                push_pixels(0, n);
                push_flushes(pend);
                new_palette();
                push_pixels(0, n);
                push_flushes(pend);
                done_beats += 2 * (n + pend);
            end
            drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct = 9;
        receiver_idle_pct = 70;

        // flush right after reset: nothing received, nothing pending
        push_flushes(1);
        drain();

        set_geometry(2, 2, MASK_ALL);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'h0001);
        push_beat(CMD_PIXEL, 16'h0000);
        push_flushes(2);
        drain();
        // mask change between results of one frame
        write_register(REG_NEIGHBOR_MASK, MASK_CENTER_ONLY);
        cfg_valid <= 1'b0;
        push_flushes(2);
        push_flushes(1);
        repeat (4) push_beat(CMD_PIXEL, 16'h8000);
        push_flushes(1);
        push_beat(CMD_PIXEL, 16'h0001);
        push_beat(CMD_PIXEL, 16'h7FFF);
        push_beat(CMD_PIXEL, 16'h0001);
        push_beat(CMD_PIXEL, 16'h5555);
        push_flushes(4);
        drain();

        random_frames(145);

        sender_idle_pct = 70;
        receiver_idle_pct = 9;
        random_frames(145);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // widest row and tallest column, each cut short and dropped by the next write
        set_geometry(2047, 0, MASK_RESET);
        new_palette();
        push_pixels(0, 48);
        push_flushes(1);
        drain();
        set_geometry(0, 2047, MASK_ALL);
        new_palette();
        push_pixels(0, 64);
        drain();
        random_frames(140);

        $display("covered %0d pixel beats and %0d flush beats over %0d register writes",
                 pixel_beats, flush_beats, reg_writes);
        $display("checked %0d results in %0d frames, %0d of them boundary pixels",
                 results_seen, frames_done, boundary_hits);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
